>>> src/mlnp_pkg.sv
// Shared types and constants of the mono last-note-priority voice controller.
// Used by the datapath, the controller, the top level and the checker.
`default_nettype none

package mlnp_pkg;

  // Event kinds on the input tuser.
  localparam logic FUNC_ON  = 1'b0;
  localparam logic FUNC_OFF = 1'b1;

  // Voice commands on the output tuser.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_GLIDE = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Input tdata: channel, note, velocity, tail_off, padded to whole bytes.
  localparam int IN_W = 24;
  localparam int ENTRY_W = 18;
  localparam int TAIL_BIT = 18;

  // Output tdata holds 20 fixed bits ahead of the stack count.
  localparam int OUT_FIXED_W = 20;

  // One held note; channel sits in the lowest bits.
  typedef struct packed {
    logic [6:0] velocity;
    logic [6:0] note;
    logic [3:0] channel;
  } entry_t;

  typedef struct packed {
    logic capture;   // take the accepted item
    logic rd_en;     // read the next stack entry
    logic commit;    // stack count takes the compacted size
    logic append;    // push the event on top
    logic load_out;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic is_on;
    logic full;
    logic empty;
    logic rd_last;
  } status_t;

endpackage

`default_nettype wire

>>> src/mlnp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mlnp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/mlnp_dp.sv
// Datapath: event registers, held-note stack in RAM, scan and compaction,
// result formatting and output register. Depends on mlnp_pkg and mlnp_ram.
`default_nettype none

module mlnp_dp #(
  parameter int STACK_DEPTH = 16,
  parameter int OUT_W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mlnp_pkg::cmd_t              cmd,
  output mlnp_pkg::status_t           st,
  input  logic [mlnp_pkg::IN_W-1:0]   s_tdata,
  input  logic [0:0]                  s_tuser,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  output logic [OUT_W-1:0]            m_tdata,
  output logic [1:0]                  m_tuser
);

  import mlnp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic          ev_func;
  entry_t        ev;
  logic          ev_tail;
  logic          was_sounding;
  logic [CW-1:0] count;
  logic          legato;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_at;
  logic          rd_vld;
  logic [CW-1:0] wr_idx;
  entry_t        last_kept;
  logic [ENTRY_W-1:0] rd_word;
  entry_t        rd_data;
  logic          drop;
  logic          keep;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [1:0]    res_action;
  logic          res_glide;
  entry_t        res_entry;
  logic          res_tail;

  assign rd_data = entry_t'(rd_word);

  // A full stack on note-on drops its oldest entry; a note-off drops matches.
  assign drop = (ev_func == FUNC_ON) ? (rd_at == '0)
              : (rd_data.channel == ev.channel && rd_data.note == ev.note);
  assign keep = rd_vld && !drop;

  assign ram_we    = keep || cmd.append;
  assign ram_waddr = cmd.append ? count[AW-1:0] : wr_idx[AW-1:0];
  assign ram_wdata = cmd.append ? ev : rd_data;

  mlnp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(rd_idx),
    .rdata(rd_word)
  );

  assign st.is_on   = (ev_func == FUNC_ON);
  assign st.full    = (count == CW'(STACK_DEPTH));
  assign st.empty   = (count == '0);
  assign st.rd_last = (CW'(rd_idx) == count - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      legato <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        legato <= cfg_wdata;
      end
      rd_vld <= cmd.rd_en;
      if (cmd.commit) begin
        count <= wr_idx;
      end else if (cmd.append) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_func      <= s_tuser[0];
      ev           <= entry_t'(s_tdata[ENTRY_W-1:0]);
      ev_tail      <= s_tdata[TAIL_BIT];
      was_sounding <= (count != '0);
      rd_idx       <= '0;
      wr_idx       <= '0;
    end else begin
      if (cmd.rd_en) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (keep) begin
        wr_idx <= wr_idx + CW'(1);
      end
    end
    if (cmd.rd_en) begin
      rd_at <= rd_idx;
    end
    if (keep) begin
      last_kept <= rd_data;
    end
  end

  // After a note-off scan the last kept entry is the new top of the stack.
  always_comb begin
    res_tail  = 1'b0;
    res_entry = ev;
    if (ev_func == FUNC_ON) begin
      if (was_sounding && legato) begin
        res_action = ACT_GLIDE;
        res_glide  = 1'b0;
      end else begin
        res_action = ACT_START;
        res_glide  = was_sounding;
      end
    end else if (count == '0) begin
      res_action        = ACT_STOP;
      res_glide         = 1'b0;
      res_entry.channel = '0;
      res_entry.note    = '0;
      res_tail          = ev_tail;
    end else begin
      res_entry = last_kept;
      if (legato) begin
        res_action = ACT_GLIDE;
        res_glide  = 1'b0;
      end else begin
        res_action = ACT_START;
        res_glide  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= res_action;
      m_tdata <= OUT_W'({count, res_tail, res_entry, res_glide});
    end
  end

endmodule

`default_nettype wire

>>> src/mlnp_ctrl.sv
// Controller state machine: input handshake, stack scan sequencing and
// output valid. Depends on mlnp_pkg for the command and status structs.
`default_nettype none

module mlnp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  mlnp_pkg::status_t st,
  output mlnp_pkg::cmd_t    cmd
);

  import mlnp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       m_tvalid_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = s_tvalid && s_tready;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        priority if (st.is_on && !st.full) begin
          state_next = S_APPEND;
        end else if (!st.is_on && st.empty) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (st.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = st.is_on ? S_APPEND : S_FINISH;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

>>> src/mono_last_note_priority.sv
// Top level of the monophonic last-note-priority voice controller.
// Depends on mlnp_pkg, mlnp_ctrl and mlnp_dp.
//
// Each note event on the input stream gives exactly one voice command on the
// output stream. The block works on one item at a time. A note-on with room on
// the stack is appended without a scan, and a note-off on an empty stack gives
// its stop without one. A note-off on a held stack and a note-on on a full
// stack first scan the held-note stack, which lives in a RAM with one read and
// one write port and is compacted one entry per cycle. A finished result waits
// in the output register while the next item is accepted; it is held until
// taken. legato_enable is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle; the block itself does not enforce this.
`default_nettype none

module mono_last_note_priority #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // channel[3:0], note[10:4], velocity[17:11], tail_off[18], zero padding
  input  logic [mlnp_pkg::IN_W-1:0]             s_tdata,
  // func[0]
  input  logic [0:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // glide_on_start[0], out_channel[4:1], out_note[11:5], out_velocity[18:12],
  // out_tail_off[19], stack_count from bit 20 up, zero padding
  output logic [((mlnp_pkg::OUT_FIXED_W + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                                m_tdata,
  // action[1:0]
  output logic [1:0]                            m_tuser,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata
);

  import mlnp_pkg::*;

  localparam int OUT_W = ((OUT_FIXED_W + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8;

  cmd_t    cmd;
  status_t st;

  mlnp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .st      (st),
    .cmd     (cmd)
  );

  mlnp_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

>>> src/mlnp_checker.sv
// Port-level checker for mono_last_note_priority, attached by bind.
// Depends on mlnp_pkg for the command codes.
`default_nettype none

module mlnp_checker #(
  parameter int STACK_DEPTH = 16
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((mlnp_pkg::OUT_FIXED_W + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                               m_tdata,
  input logic [1:0]                            m_tuser
);

  import mlnp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] out_count;

  assign out_count = m_tdata[OUT_FIXED_W + CW - 1:OUT_FIXED_W];

  // A result that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted before the first finished");

  // A stop leaves nothing held and names no note.
  a_stop_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ACT_STOP |->
      out_count == '0 && m_tdata[11:1] == '0 && m_tdata[0] == 1'b0)
    else $error("stop with notes still held");

  // Any command other than stop leaves at least one note held.
  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ACT_START || m_tuser == ACT_GLIDE) |->
      out_count != '0 && m_tdata[19] == 1'b0)
    else $error("start or glide with an empty stack");

endmodule

bind mono_last_note_priority mlnp_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the mono last-note-priority voice controller.
// Depends on mlnp_pkg and mono_last_note_priority; keeps its own held-note
// stack to predict every voice command and checks the output stream in order.

module testbench;
  import mlnp_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int OUT_W = ((OUT_FIXED_W + CNT_W + 7) / 8) * 8;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 228;

  typedef struct packed {
    logic [1:0]       action;
    logic             glide_on_start;
    logic [3:0]       channel;
    logic [6:0]       note;
    logic [6:0]       velocity;
    logic             tail_off;
    logic [CNT_W-1:0] stack_count;
  } voice_cmd_t;

  typedef enum logic {ROW_EVENT, ROW_LEGATO} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic       func;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       tail_off;
    logic       legato_value;
    bit         typed;
    voice_cmd_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [0:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b0;

  // Predicted copy of the block's state.
  entry_t held_notes [STACK_DEPTH];
  int     held_total = 0;
  logic   legato = 1'b0;

  voice_cmd_t pending_cmds[$];
  int         mismatches = 0;
  bit         no_idle = 1'b0;

  always #6 clk = ~clk;

  mono_last_note_priority #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic voice_cmd_t voice_cmd(logic [1:0] action, logic glide, logic [3:0] ch,
                                           logic [6:0] nt, logic [6:0] vel, logic tail,
                                           int count);
    voice_cmd_t cmd;
    cmd = {action, glide, ch, nt, vel, tail, CNT_W'(count)};
    return cmd;
  endfunction

  function automatic stim_row_t event_row(logic func, logic [3:0] ch, logic [6:0] nt,
                                          logic [6:0] vel, logic tail, bit typed,
                                          voice_cmd_t want);
    stim_row_t row;
    row.kind = ROW_EVENT;
    row.func = func;
    row.channel = ch;
    row.note = nt;
    row.velocity = vel;
    row.tail_off = tail;
    row.legato_value = 1'b0;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t legato_row(logic value);
    stim_row_t row;
    row = event_row(FUNC_ON, '0, '0, '0, 1'b0, 1'b0, '0);
    row.kind = ROW_LEGATO;
    row.legato_value = value;
    return row;
  endfunction

  // Updates the held-note stack for one event and returns the voice command.
  task automatic predict_voice_cmd(input logic func, input logic [3:0] ch,
                                   input logic [6:0] nt, input logic [6:0] vel,
                                   input logic tail, output voice_cmd_t cmd);
    bit     sounding;
    int     kept;
    entry_t top;
    cmd = '0;
    if (func == FUNC_ON) begin
      sounding = held_total > 0;
      if (held_total >= STACK_DEPTH) begin
        for (int i = 1; i < STACK_DEPTH; i++) held_notes[i-1] = held_notes[i];
        held_total = STACK_DEPTH - 1;
      end
      held_notes[held_total] = {vel, nt, ch};
      held_total++;
      cmd.action = (sounding && legato) ? ACT_GLIDE : ACT_START;
      cmd.glide_on_start = sounding && !legato;
      cmd.channel = ch;
      cmd.note = nt;
      cmd.velocity = vel;
    end else begin
      kept = 0;
      for (int i = 0; i < held_total; i++) begin
        if (!(held_notes[i].channel == ch && held_notes[i].note == nt)) begin
          held_notes[kept] = held_notes[i];
          kept++;
        end
      end
      held_total = kept;
      if (held_total == 0) begin
        cmd.action = ACT_STOP;
        cmd.velocity = vel;
        cmd.tail_off = tail;
      end else begin
        top = held_notes[held_total-1];
        cmd.action = legato ? ACT_GLIDE : ACT_START;
        cmd.glide_on_start = !legato;
        cmd.channel = top.channel;
        cmd.note = top.note;
        cmd.velocity = top.velocity;
      end
    end
    cmd.stack_count = CNT_W'(held_total);
  endtask

  // The valid stays high from one item to the next when there is no gap, so
  // it is only lowered before an item that draws a gap.
  task automatic send_event(input logic func, input logic [3:0] ch, input logic [6:0] nt,
                            input logic [6:0] vel, input logic tail, input bit typed,
                            input voice_cmd_t want);
    int         gap;
    voice_cmd_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {5'b0, tail, vel, nt, ch};
    do @(posedge clk); while (!s_tready);
    predict_voice_cmd(func, ch, nt, vel, tail, predicted);
    pending_cmds.insert(pending_cmds.size(), typed ? want : predicted);
  endtask

  task automatic set_legato(input logic value);
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    legato = value;
  endtask

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_voice_cmd();
    voice_cmd_t want, got;
    got = {m_tuser, m_tdata[0], m_tdata[4:1], m_tdata[11:5], m_tdata[18:12], m_tdata[19],
           m_tdata[20 +: CNT_W]};
    if (pending_cmds.size() == 0) begin
      $error("voice command with none expected: action %0d note %0d", got.action, got.note);
      mismatches++;
      return;
    end
    want = pending_cmds.pop_front();
    compare_field("action", int'(want.action), int'(got.action));
    compare_field("glide_on_start", int'(want.glide_on_start), int'(got.glide_on_start));
    compare_field("out_channel", int'(want.channel), int'(got.channel));
    compare_field("out_note", int'(want.note), int'(got.note));
    compare_field("out_velocity", int'(want.velocity), int'(got.velocity));
    compare_field("out_tail_off", int'(want.tail_off), int'(got.tail_off));
    compare_field("stack_count", int'(want.stack_count), int'(got.stack_count));
  endtask

  // Result side: stall a random number of cycles before each item.
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_voice_cmd();
    end
  end

  initial begin
    stim_row_t  rows[$];
    int         on_pct;
    int         pick;
    logic       func;
    logic [3:0] ch;
    logic [6:0] nt;
    logic [6:0] vel;
    logic       tail;

    // Retrigger mode from reset.
    rows.insert(rows.size(), event_row(FUNC_OFF, 4'd5, 7'd60, 7'd127, 1'b1, 1'b1,
                voice_cmd(ACT_STOP, 1'b0, 4'd0, 7'd0, 7'd127, 1'b1, 0)));
    rows.insert(rows.size(), event_row(FUNC_ON, 4'd15, 7'd127, 7'd127, 1'b0, 1'b1,
                voice_cmd(ACT_START, 1'b0, 4'd15, 7'd127, 7'd127, 1'b0, 1)));
    rows.insert(rows.size(), event_row(FUNC_ON, 4'd0, 7'd0, 7'd0, 1'b1, 1'b1,
                voice_cmd(ACT_START, 1'b1, 4'd0, 7'd0, 7'd0, 1'b0, 2)));
    // A repeated note, then one note-off that clears both copies.
    rows.insert(rows.size(), event_row(FUNC_ON, 4'd0, 7'd0, 7'd64, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), event_row(FUNC_OFF, 4'd0, 7'd0, 7'd10, 1'b1, 1'b0, '0));
    // Note-off for a note that is not held.
    rows.insert(rows.size(), event_row(FUNC_OFF, 4'd2, 7'd2, 7'd3, 1'b1, 1'b0, '0));
    rows.insert(rows.size(), event_row(FUNC_OFF, 4'd15, 7'd127, 7'd0, 1'b0, 1'b1,
                voice_cmd(ACT_STOP, 1'b0, 4'd0, 7'd0, 7'd0, 1'b0, 0)));
    // Legato mode.
    rows.insert(rows.size(), legato_row(1'b1));
    rows.insert(rows.size(), event_row(FUNC_ON, 4'd1, 7'd10, 7'd20, 1'b0, 1'b1,
                voice_cmd(ACT_START, 1'b0, 4'd1, 7'd10, 7'd20, 1'b0, 1)));
    rows.insert(rows.size(), event_row(FUNC_ON, 4'd2, 7'd20, 7'd30, 1'b1, 1'b1,
                voice_cmd(ACT_GLIDE, 1'b0, 4'd2, 7'd20, 7'd30, 1'b0, 2)));
    rows.insert(rows.size(), event_row(FUNC_OFF, 4'd2, 7'd20, 7'd5, 1'b1, 1'b1,
                voice_cmd(ACT_GLIDE, 1'b0, 4'd1, 7'd10, 7'd20, 1'b0, 1)));
    rows.insert(rows.size(), event_row(FUNC_OFF, 4'd1, 7'd10, 7'd99, 1'b1, 1'b1,
                voice_cmd(ACT_STOP, 1'b0, 4'd0, 7'd0, 7'd99, 1'b1, 0)));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_LEGATO) begin
        set_legato(rows[r].legato_value);
      end else begin
        send_event(rows[r].func, rows[r].channel, rows[r].note, rows[r].velocity,
                   rows[r].tail_off, rows[r].typed, rows[r].want);
      end
    end

    // Fill the stack and push one past full so the oldest note is dropped.
    for (int i = 0; i <= STACK_DEPTH; i++) begin
      send_event(FUNC_ON, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 1'b0, '0);
    end

    // Random phases alternate the legato setting and sweep the note-on share,
    // so the stack runs both full and empty.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      set_legato(1'(phase % 2));
      unique case ((phase / 2) % 4)
        0: begin
          on_pct = 85;
        end
        1: begin
          on_pct = 40;
        end
        2: begin
          on_pct = 70;
        end
        default: begin
          on_pct = 25;
        end
      endcase
      no_idle = (phase == 2 || phase == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        func = ($urandom_range(0, 99) < on_pct) ? FUNC_ON : FUNC_OFF;
        ch = 4'($urandom_range(0, 15));
        nt = 7'($urandom_range(0, 127));
        vel = 7'($urandom_range(0, 127));
        tail = 1'($urandom_range(0, 1));
        if (func == FUNC_ON && $urandom_range(0, 3) != 0) begin
          // A narrow pool of notes makes repeated note-ons common.
          ch = 4'($urandom_range(0, 2));
          nt = 7'($urandom_range(60, 66));
        end else if (func == FUNC_OFF && held_total > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, held_total - 1);
          ch = held_notes[pick].channel;
          nt = held_notes[pick].note;
        end
        send_event(func, ch, nt, vel, tail, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/mlnp_pkg.sv
src/mlnp_ram.sv
src/mlnp_dp.sv
src/mlnp_ctrl.sv
src/mono_last_note_priority.sv
src/mlnp_checker.sv
bench/testbench.sv
